// File: rtl/pdxc_pkg.sv
// Shared types and constants for the packet deframer with XOR checksum.
package pdxc_pkg;

    localparam int IDLE_COUNT_WIDTH_DEF = 16;

    localparam logic [7:0]  START_BYTE_RST    = 8'd170;
    localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd256;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_HDR_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_PAY_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_TOO_LONG    = 3'd3;
    localparam logic [2:0] ST_BAD_SUM     = 3'd4;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] max_payload;
        logic [15:0] timeout_ticks;
    } pdxc_cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  packet_type;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [2:0]  status;
        logic        last;
    } pdxc_res_t;

endpackage

// File: rtl/packet_deframer_xor_checksum.sv
// Top level of the packet deframer: config registers, framing core and output buffer.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tuser cmd, tdata rx_byte
//  m_*     | out       | m_tvalid/m_tready  | tuser result_kind, tdata fields, tlast last
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle while s_tready is high; each word is processed in the cycle
// it is accepted and its result, if any, lands in the output buffer on that edge.
// The two-entry output buffer sets the stall: s_tready drops only while its skid
// stage holds a word. cfg_ready is always high.
// Reset clears the framer to hunt and loads the register defaults; no clearing pass.
module packet_deframer_xor_checksum
    import pdxc_pkg::*;
#(
    parameter int IDLE_COUNT_WIDTH = IDLE_COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  logic                   s_tuser,   // [0] cmd
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // [7:0] packet_type, [15:8] data_byte,
                                              // [31:16] byte_index, [34:32] status, rest 0
    output logic                   m_tuser,   // [0] result_kind
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    pdxc_cfg_t cfg_reg;
    logic      in_fire;
    logic      res_valid;
    pdxc_res_t res;
    pdxc_res_t out_res;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.max_payload   <= MAX_PAYLOAD_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_BYTE:    cfg_reg.start_byte    <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:   cfg_reg.max_payload   <= cfg_data;
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default:           ;
            endcase
        end
    end

    pdxc_core #(
        .IDLE_COUNT_WIDTH(IDLE_COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_fire),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    pdxc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_res   (res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_res    (out_res),
        .out_ready  (m_tready)
    );

    assign m_tdata = {5'd0, out_res.status, out_res.byte_index,
                      out_res.data_byte, out_res.packet_type};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// File: rtl/pdxc_core.sv
// Framing state machine: header parse, payload indexing, checksum and idle timeout.
module pdxc_core
    import pdxc_pkg::*;
#(
    parameter int IDLE_COUNT_WIDTH = IDLE_COUNT_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pdxc_cfg_t cfg,
    input  logic      in_valid,
    input  logic      in_cmd,
    input  logic [7:0] in_byte,
    output logic      res_valid,
    output pdxc_res_t res
);

    localparam int CMP_W = (IDLE_COUNT_WIDTH > 16) ? IDLE_COUNT_WIDTH : 16;
    localparam logic [IDLE_COUNT_WIDTH-1:0] IDLE_MAX = '1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  type_reg, type_next;
    logic [15:0]                 exp_len_reg, exp_len_next;
    logic [15:0]                 seen_reg, seen_next;
    logic [7:0]                  xor_reg, xor_next;
    logic [IDLE_COUNT_WIDTH-1:0] idle_reg, idle_next;

    logic [IDLE_COUNT_WIDTH-1:0] idle_inc;
    logic [15:0]                 limit;
    logic                        timed_out;
    logic [15:0]                 len_full;
    logic [15:0]                 seen_inc;

    assign idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign limit     = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
    assign timed_out = (CMP_W'(idle_inc) >= CMP_W'(limit)) || (idle_inc == IDLE_MAX);
    assign len_full  = {in_byte, exp_len_reg[7:0]};
    assign seen_inc  = seen_reg + 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        xor_next     = xor_reg;
        idle_next    = idle_reg;
        res_valid    = 1'b0;
        res.kind        = KIND_STATUS;
        res.packet_type = type_reg;
        res.data_byte   = 8'd0;
        res.byte_index  = 16'd0;
        res.status      = ST_OK;
        res.last        = 1'b1;

        if (in_valid)
        begin
            if (in_cmd == CMD_TICK)
            begin
                if (phase_reg == PH_HUNT)
                begin
                    idle_next = '0;
                end
                else if (timed_out)
                begin
                    res_valid  = 1'b1;
                    res.status = (phase_reg inside {PH_TYPE, PH_LEN_LO, PH_LEN_HI}) ?
                                 ST_HDR_TIMEOUT : ST_PAY_TIMEOUT;
                    phase_next = PH_HUNT;
                    idle_next  = '0;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_byte == cfg.start_byte)
                        begin
                            type_next    = 8'd0;
                            exp_len_next = 16'd0;
                            seen_next    = 16'd0;
                            xor_next     = in_byte;
                            phase_next   = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next  = in_byte;
                        xor_next   = xor_reg ^ in_byte;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        exp_len_next = {8'd0, in_byte};
                        xor_next     = xor_reg ^ in_byte;
                        phase_next   = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        exp_len_next = len_full;
                        xor_next     = xor_reg ^ in_byte;
                        if (len_full > cfg.max_payload)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TOO_LONG;
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            seen_next  = 16'd0;
                            phase_next = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        xor_next       = xor_reg ^ in_byte;
                        res_valid      = 1'b1;
                        res.kind       = KIND_PAYLOAD;
                        res.data_byte  = in_byte;
                        res.byte_index = seen_reg;
                        res.last       = 1'b0;
                        seen_next      = seen_inc;
                        if (seen_inc >= exp_len_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    default:
                    begin
                        res_valid  = 1'b1;
                        res.status = (xor_reg == in_byte) ? ST_OK : ST_BAD_SUM;
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            type_reg    <= 8'd0;
            exp_len_reg <= 16'd0;
            seen_reg    <= 16'd0;
            xor_reg     <= 8'd0;
            idle_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
            idle_reg    <= idle_next;
        end
    end

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |=> phase_reg == PH_HUNT)
        else $error("packet end did not return to hunt");

    a_payload_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_PAYLOAD |-> phase_reg == PH_PAYLOAD)
        else $error("payload word outside payload phase");

    a_hunt_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> idle_reg == '0)
        else $error("idle count running while hunting");

endmodule

// File: rtl/pdxc_out_buf.sv
// Result register with skid stage for the master-side stream.
module pdxc_out_buf
    import pdxc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pdxc_res_t push_res,
    output logic      can_accept,
    output logic      out_valid,
    output pdxc_res_t out_res,
    input  logic      out_ready
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    pdxc_res_t main_reg;
    pdxc_res_t skid_reg;
    logic      pop;

    assign pop        = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_res    = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_res;
            end
            else
            begin
                skid_reg <= push_res;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word held with empty main register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg))
        else $error("word pushed into full buffer");

endmodule
